// ===== hdl/assert_macros.svh =====
// Assertion macros used by the RTL of the priority drop task queue.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Check that a condition holds at every clock edge out of reset.
`define ASSERT_ALWAYS(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
		else $error("assertion failed: invariant");

// Check that a consequent holds at the same edge as its antecedent.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed: implication");

`else

`define ASSERT_ALWAYS(label, clk, rst_n, cond)
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== hdl/pdtq_pkg.sv =====
// Package with constants, codes and types of the priority drop task queue.
package pdtq_pkg;

	localparam int DEPTH = 16;
	localparam int IDX_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	localparam int CMD_W = 2;
	localparam int PRI_W = 8;
	localparam int TS_W  = 63;
	localparam int PAY_W = 32;
	localparam int CAP_W = 5;
	localparam int ST_W  = 2;

	localparam logic [CMD_W-1:0] CMD_PUSH  = 2'd0;
	localparam logic [CMD_W-1:0] CMD_POP   = 2'd1;
	localparam logic [CMD_W-1:0] CMD_CLOSE = 2'd2;

	localparam logic [ST_W-1:0] ST_OK     = 2'd0;
	localparam logic [ST_W-1:0] ST_REJECT = 2'd1;
	localparam logic [ST_W-1:0] ST_EMPTY  = 2'd2;
	localparam logic [ST_W-1:0] ST_CLOSED = 2'd3;

	typedef logic [IDX_W-1:0] idx_t;
	typedef logic [CNT_W-1:0] cnt_t;

	typedef struct packed {
		logic [PRI_W-1:0] pri;
		logic [TS_W-1:0]  ts;
		logic [PAY_W-1:0] pay;
	} slot_t;

	localparam int SLOT_W = $bits(slot_t);

	// Step a ring index forward, wrapping at the active capacity.
	function automatic idx_t wrap_inc(idx_t i, cnt_t cap);
		idx_t r;
		if (CNT_W'(i) + CNT_W'(1) == cap) begin
			r = '0;
		end else begin
			r = i + IDX_W'(1);
		end
		return r;
	endfunction

endpackage

// ===== hdl/pdtq_ram.sv =====
// Generic single write, single read RAM with registered read data.
module pdtq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ===== hdl/priority_drop_task_queue.sv =====
// Top level of the priority drop task queue: ring control, victim scan, result register.
// Push into a non-full queue, pop and shutdown go from the transfer through DECIDE and then
// PUSH, POP or FIN into the result register. A push into a full queue scans every stored
//   slot through the one RAM read port in SCAN, then DRAIN and EVICT. The next transfer is
//   taken as soon as the previous result sits in the output register.
// Reset (arst_n low): queue empty, not shut down, capacity 16; slot RAM is not cleared.
module priority_drop_task_queue (
	input  logic                       clk,
	input  logic                       arst_n,
	// configuration
	input  logic                       cfg_we,
	input  logic [pdtq_pkg::CAP_W-1:0] capacity,
	// input channel
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [pdtq_pkg::CMD_W-1:0] command,
	input  logic [pdtq_pkg::PRI_W-1:0] in_priority,
	input  logic [pdtq_pkg::TS_W-1:0]  in_timestamp,
	input  logic [pdtq_pkg::PAY_W-1:0] in_payload,
	input  logic [pdtq_pkg::TS_W-1:0]  now_time,
	// output channel
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [pdtq_pkg::ST_W-1:0]  status,
	output logic [pdtq_pkg::PRI_W-1:0] out_priority,
	output logic [pdtq_pkg::TS_W-1:0]  out_timestamp,
	output logic [pdtq_pkg::PAY_W-1:0] out_payload,
	output logic                       dropped_valid,
	output logic [pdtq_pkg::PAY_W-1:0] dropped_payload,
	output logic [pdtq_pkg::CAP_W-1:0] occupancy,
	output logic                       queue_full
);

	import pdtq_pkg::*;

	`include "assert_macros.svh"

	// Sequencer codes
	localparam logic [2:0] S_IDLE   = 3'd0;  // wait for an input transfer
	localparam logic [2:0] S_DECIDE = 3'd1;  // classify the latched command
	localparam logic [2:0] S_SCAN   = 3'd2;  // issue one slot read per cycle
	localparam logic [2:0] S_DRAIN  = 3'd3;  // last slot read comes back
	localparam logic [2:0] S_EVICT  = 3'd4;  // evict or reject, write new task
	localparam logic [2:0] S_PUSH   = 3'd5;  // plain append at the tail
	localparam logic [2:0] S_POP    = 3'd6;  // head slot data is on the RAM port
	localparam logic [2:0] S_FIN    = 3'd7;  // result without RAM data

	logic [2:0] state_q, state_d;

	// Ring control
	idx_t head_q, head_d;
	idx_t tail_q, tail_d;
	cnt_t cnt_q, cnt_d;
	cnt_t cap_q;
	logic closed_q, closed_d;

	// Latched request
	logic [CMD_W-1:0] cmd_q;
	slot_t            req_q;

	// Victim scan
	idx_t  ptr_q, ptr_d;
	cnt_t  scan_n_q, scan_n_d;
	logic  vld_s1;
	logic  first_s1;
	idx_t  idx_s1;
	idx_t  best_idx_q;
	slot_t best_q;
	logic  better;

	// RAM ports
	logic  wr_en, rd_en;
	idx_t  wr_addr, rd_addr;
	slot_t wr_data, rd_data;

	// Result register
	logic             out_valid_q;
	logic             out_free;
	logic             load;
	logic [ST_W-1:0]  r_status;
	slot_t            r_slot;
	logic             r_dv;
	logic [PAY_W-1:0] r_dpay;
	logic [ST_W-1:0]  res_status_q;
	slot_t            res_slot_q;
	logic             res_dv_q;
	logic [PAY_W-1:0] res_dpay_q;
	cnt_t             res_cnt_q;
	logic             res_full_q;

	logic in_xfer;

	assign in_stall = (state_q != S_IDLE);
	assign in_xfer  = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;

	// Lowest priority wins, then the oldest; a full tie keeps the earlier slot
	assign better = first_s1 || (rd_data.pri < best_q.pri) ||
		((rd_data.pri == best_q.pri) && (rd_data.ts < best_q.ts));

	pdtq_ram #(
		.WIDTH(SLOT_W),
		.DEPTH(DEPTH)
	) u_slots (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	always_comb begin
		state_d  = state_q;
		head_d   = head_q;
		tail_d   = tail_q;
		cnt_d    = cnt_q;
		closed_d = closed_q;
		ptr_d    = ptr_q;
		scan_n_d = scan_n_q;
		rd_en    = 1'b0;
		rd_addr  = head_q;
		wr_en    = 1'b0;
		wr_addr  = tail_q;
		wr_data  = req_q;
		load     = 1'b0;
		r_status = ST_OK;
		r_slot   = '0;
		r_dv     = 1'b0;
		r_dpay   = '0;

		unique case (state_q)
			S_IDLE: begin
				if (in_xfer) begin
					state_d = S_DECIDE;
				end
			end
			S_DECIDE: begin
				unique case (cmd_q)
					CMD_PUSH: begin
						if (cnt_q < cap_q) begin
							state_d = S_PUSH;
						end else begin
							// Full: sweep every stored slot from the head
							ptr_d    = head_q;
							scan_n_d = '0;
							state_d  = S_SCAN;
						end
					end
					CMD_POP: begin
						if (closed_q || (cnt_q == '0)) begin
							state_d = S_FIN;
						end else begin
							rd_en   = 1'b1;
							rd_addr = head_q;
							state_d = S_POP;
						end
					end
					CMD_CLOSE: begin
						closed_d = 1'b1;
						state_d  = S_FIN;
					end
					default: begin
						state_d = S_FIN;
					end
				endcase
			end
			S_SCAN: begin
				rd_en    = 1'b1;
				rd_addr  = ptr_q;
				ptr_d    = wrap_inc(ptr_q, cap_q);
				scan_n_d = scan_n_q + CNT_W'(1);
				if (scan_n_q == cnt_q - CNT_W'(1)) begin
					state_d = S_DRAIN;
				end
			end
			S_DRAIN: begin
				state_d = S_EVICT;
			end
			S_EVICT: begin
				if (out_free) begin
					load = 1'b1;
					if (best_q.pri <= req_q.pri) begin
						r_dv   = 1'b1;
						r_dpay = best_q.pay;
						wr_en  = 1'b1;
						if (best_idx_q == head_q) begin
							// Head victim: advance head, append at tail
							head_d  = wrap_inc(head_q, cap_q);
							wr_addr = tail_q;
							tail_d  = wrap_inc(tail_q, cap_q);
						end else begin
							// Tail or middle victim: new task takes the slot, tail holds
							wr_addr = best_idx_q;
						end
					end else begin
						r_status = ST_REJECT;
					end
					state_d = S_IDLE;
				end
			end
			S_PUSH: begin
				if (out_free) begin
					load    = 1'b1;
					wr_en   = 1'b1;
					wr_addr = tail_q;
					tail_d  = wrap_inc(tail_q, cap_q);
					cnt_d   = cnt_q + CNT_W'(1);
					state_d = S_IDLE;
				end
			end
			S_POP: begin
				if (out_free) begin
					load    = 1'b1;
					r_slot  = rd_data;
					head_d  = wrap_inc(head_q, cap_q);
					cnt_d   = cnt_q - CNT_W'(1);
					state_d = S_IDLE;
				end
			end
			S_FIN: begin
				if (out_free) begin
					load = 1'b1;
					if (cmd_q == CMD_POP) begin
						r_status = closed_q ? ST_CLOSED : ST_EMPTY;
					end
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			head_q      <= '0;
			tail_q      <= '0;
			cnt_q       <= '0;
			cap_q       <= CNT_W'(DEPTH);
			closed_q    <= 1'b0;
			ptr_q       <= '0;
			scan_n_q    <= '0;
			vld_s1      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			closed_q <= closed_d;
			ptr_q    <= ptr_d;
			scan_n_q <= scan_n_d;
			vld_s1   <= (state_q == S_SCAN);
			if (cfg_we) begin
				// Capacity write empties the ring; clamp to 1..DEPTH
				if (capacity == '0) begin
					cap_q <= CNT_W'(1);
				end else if (32'(capacity) > DEPTH) begin
					cap_q <= CNT_W'(DEPTH);
				end else begin
					cap_q <= CNT_W'(capacity);
				end
				head_q <= '0;
				tail_q <= '0;
				cnt_q  <= '0;
			end else begin
				head_q <= head_d;
				tail_q <= tail_d;
				cnt_q  <= cnt_d;
			end
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			cmd_q       <= command;
			req_q.pri   <= in_priority;
			req_q.ts    <= (in_timestamp == '0) ? now_time : in_timestamp;
			req_q.pay   <= in_payload;
		end
		first_s1 <= (scan_n_q == '0);
		idx_s1   <= ptr_q;
		if (vld_s1 && better) begin
			best_q     <= rd_data;
			best_idx_q <= idx_s1;
		end
		if (load) begin
			res_status_q <= r_status;
			res_slot_q   <= r_slot;
			res_dv_q     <= r_dv;
			res_dpay_q   <= r_dpay;
			res_cnt_q    <= cnt_d;
			res_full_q   <= (cnt_d >= cap_q);
		end
	end

	assign out_valid       = out_valid_q;
	assign status          = res_status_q;
	assign out_priority    = res_slot_q.pri;
	assign out_timestamp   = res_slot_q.ts;
	assign out_payload     = res_slot_q.pay;
	assign dropped_valid   = res_dv_q;
	assign dropped_payload = res_dpay_q;
	assign occupancy       = CAP_W'(res_cnt_q);
	assign queue_full      = res_full_q;

	`ASSERT_ALWAYS(a_cnt_le_cap, clk, arst_n, cnt_q <= cap_q)
	`ASSERT_ALWAYS(a_ptr_in_ring, clk, arst_n, (CNT_W'(head_q) < cap_q) && (CNT_W'(tail_q) < cap_q))
	`ASSERT_IMPLY(a_scan_only_full, clk, arst_n, state_q == S_SCAN, cnt_q == cap_q)
	`ASSERT_ALWAYS(a_no_rw_overlap, clk, arst_n, !(wr_en && rd_en))
	`ASSERT_IMPLY(a_drop_ok_full, clk, arst_n, out_valid_q && res_dv_q, (res_status_q == ST_OK) && res_full_q)

endmodule
